[sv/pmm_pkg.sv]
package pmm_pkg;

  localparam int VA_W   = 14;
  localparam int PA_W   = 14;
  localparam int BYTE_W = 8;
  localparam int PROC_W = 6;
  localparam int CNT_W  = 7;

  // page-table pointers live at this byte of the system page
  localparam int PTR_BASE = 64;

  localparam logic [1:0] OP_NEW   = 2'd0;
  localparam logic [1:0] OP_KILL  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_STORE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;
  localparam logic [1:0] ST_NO_PROC  = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PROC_W-1:0] process_number;
    logic [CNT_W-1:0]  npages;
    logic [VA_W-1:0]   vaddr;
    logic [BYTE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [PA_W-1:0]   paddr;
    logic [BYTE_W-1:0] read_data;
    logic [1:0]        status;
  } result_t;

endpackage

[sv/paged_memory_manager.sv]
// Channel  | Ports              | Payload
// ---------+--------------------+---------------------------------------------------
// in       | in_tvalid/tready   | tuser: opcode; tdata: process, count, vaddr, wdata
// out      | out_tvalid/tready  | tuser: status; tdata: paddr, read_data
//
// After reset the memory is swept once, one byte a cycle, with in_tready low.
// Every step shares the one memory port. A load reads the table pointer, the
// table entry and the data byte in turn; a store reads the pointer and entry,
// then writes the byte. Kill frees each mapped page, then the table page and the
// pointer; new process counts free pages, then takes pages and writes its table.
// A word is accepted while a finished result waits in the output register.
module paged_memory_manager #(
  parameter int NUM_PAGES  = 64,
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic [39:0] in_tdata,   // [5:0] process_number, [12:6] npages,
                                  // [26:13] vaddr, [34:27] write_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [23:0] out_tdata   // [13:0] paddr, [21:14] read_data
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int AW = PW + OW;

  pmm_pkg::item_t             item;
  pmm_pkg::result_t           res;
  pmm_pkg::result_t           out_r;
  logic                       out_valid_r;
  logic                       seq_idle, res_valid, res_ready;
  logic                       mem_en, mem_we;
  logic [AW-1:0]              mem_addr;
  logic [pmm_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  assign item.opcode         = in_tuser;
  assign item.process_number = in_tdata[5:0];
  assign item.npages         = in_tdata[12:6];
  assign item.vaddr          = in_tdata[26:13];
  assign item.write_data     = in_tdata[34:27];

  assign in_tready = seq_idle;
  assign res_ready = !out_valid_r || out_tready;

  pmm_seq #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && seq_idle),
    .item      (item),
    .idle      (seq_idle),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pmm_mem #(
    .DEPTH (NUM_PAGES * PAGE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {2'b00, out_r.read_data, out_r.paddr};

endmodule

[sv/pmm_mem.sv]
module pmm_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [pmm_pkg::BYTE_W-1:0]   wdata,
  output logic [pmm_pkg::BYTE_W-1:0]   rdata
);

  logic [pmm_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [pmm_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/pmm_seq.sv]
module pmm_seq #(
  parameter int NUM_PAGES  = 64,
  parameter int PAGE_BYTES = 256,
  parameter int PW         = $clog2(NUM_PAGES),
  parameter int OW         = $clog2(PAGE_BYTES),
  parameter int AW         = PW + OW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  pmm_pkg::item_t              item,
  output logic                        idle,
  output logic                        mem_en,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output logic [pmm_pkg::BYTE_W-1:0]  mem_wdata,
  input  logic [pmm_pkg::BYTE_W-1:0]  mem_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pmm_pkg::result_t            res
);

  localparam int DEPTH = NUM_PAGES * PAGE_BYTES;
  localparam int CW    = $clog2(NUM_PAGES + 1);
  localparam int VPW   = pmm_pkg::VA_W - OW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PTR, S_ENT, S_LRD,
    S_CNT_RD, S_CNT_CHK, S_ALC_RD, S_ALC_CHK, S_PWR, S_EWR, S_ZFL,
    S_KRD, S_KCHK, S_KTBL, S_KPTR, S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  pmm_pkg::item_t                 item_r, item_nxt;
  pmm_pkg::result_t               res_r, res_nxt;
  logic [pmm_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PW-1:0]                  j_r, j_nxt;
  logic [CW-1:0]                  i_r, i_nxt;
  logic [CW-1:0]                  free_r, free_nxt;
  logic [PW-1:0]                  tbl_r, tbl_nxt;
  logic                           have_tbl_r, have_tbl_nxt;
  logic [AW-1:0]                  clr_r, clr_nxt;

  logic [AW-1:0]                  ptr_in_addr, ptr_addr, ent_addr;
  logic [VPW-1:0]                 vp;
  logic [OW-1:0]                  va_off;
  logic [CW-1:0]                  free_sum;
  logic                           rd_zero, rd_page;
  logic [AW-1:0]                  pa;

  assign ptr_in_addr = AW'(pmm_pkg::PTR_BASE) + AW'(item.process_number);
  assign ptr_addr    = AW'(pmm_pkg::PTR_BASE) + AW'(item_r.process_number);
  assign ent_addr    = {tbl_r, OW'(i_r[PW-1:0])};
  assign vp          = item_r.vaddr[pmm_pkg::VA_W-1:OW];
  assign va_off      = item_r.vaddr[OW-1:0];
  assign rd_zero     = (mem_rdata == '0);
  assign rd_page     = (int'(mem_rdata) < NUM_PAGES);
  assign free_sum    = free_r + CW'(rd_zero);
  assign pa          = {mem_rdata[PW-1:0], va_off};

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    cnt_nxt      = cnt_r;
    j_nxt        = j_r;
    i_nxt        = i_r;
    free_nxt     = free_r;
    tbl_nxt      = tbl_r;
    have_tbl_nxt = have_tbl_r;
    clr_nxt      = clr_r;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;

    case (state_r)
      S_CLR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = (clr_r == '0) ? pmm_pkg::BYTE_W'(1) : '0;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = item;
          res_nxt   = '0;
          cnt_nxt   = (int'(item.npages) > NUM_PAGES) ?
                      pmm_pkg::CNT_W'(NUM_PAGES) : item.npages;
          mem_en    = 1'b1;
          mem_addr  = ptr_in_addr;
          state_nxt = S_PTR;
        end
      end

      S_PTR: begin
        if (item_r.opcode == pmm_pkg::OP_NEW) begin
          if (!rd_zero) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt     = '0;
            free_nxt  = '0;
            state_nxt = S_CNT_RD;
          end
        end else if (rd_zero || !rd_page) begin
          res_nxt.status = pmm_pkg::ST_NO_PROC;
          state_nxt      = S_DONE;
        end else begin
          tbl_nxt = mem_rdata[PW-1:0];
          if (item_r.opcode == pmm_pkg::OP_KILL) begin
            i_nxt     = '0;
            state_nxt = S_KRD;
          end else if (int'(vp) >= NUM_PAGES) begin
            res_nxt.status = pmm_pkg::ST_UNMAPPED;
            state_nxt      = S_DONE;
          end else begin
            mem_en    = 1'b1;
            mem_addr  = {mem_rdata[PW-1:0], OW'(vp)};
            state_nxt = S_ENT;
          end
        end
      end

      S_ENT: begin
        if (rd_zero || !rd_page) begin
          res_nxt.status = pmm_pkg::ST_UNMAPPED;
          state_nxt      = S_DONE;
        end else begin
          res_nxt.paddr = pmm_pkg::PA_W'(pa);
          mem_en   = 1'b1;
          mem_addr = pa;
          if (item_r.opcode == pmm_pkg::OP_LOAD) begin
            state_nxt = S_LRD;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = item_r.write_data;
            state_nxt = S_DONE;
          end
        end
      end

      S_LRD: begin
        res_nxt.read_data = mem_rdata;
        state_nxt         = S_DONE;
      end

      S_CNT_RD: begin
        mem_en    = 1'b1;
        mem_addr  = AW'(j_r);
        state_nxt = S_CNT_CHK;
      end

      S_CNT_CHK: begin
        free_nxt = free_sum;
        if (j_r == PW'(NUM_PAGES - 1)) begin
          if (pmm_pkg::CNT_W'(free_sum) > cnt_r) begin
            j_nxt        = '0;
            have_tbl_nxt = 1'b0;
            state_nxt    = S_ALC_RD;
          end else begin
            res_nxt.status = pmm_pkg::ST_NO_FREE;
            state_nxt      = S_DONE;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_CNT_RD;
        end
      end

      S_ALC_RD: begin
        mem_en    = 1'b1;
        mem_addr  = AW'(j_r);
        state_nxt = S_ALC_CHK;
      end

      // if page j is free, mark it used and record it as table or entry, else try the next
      S_ALC_CHK: begin
        if (rd_zero) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = AW'(j_r);
          mem_wdata = pmm_pkg::BYTE_W'(1);
          if (have_tbl_r) begin
            state_nxt = S_EWR;
          end else begin
            tbl_nxt   = j_r;
            state_nxt = S_PWR;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ALC_RD;
        end
      end

      S_PWR: begin
        mem_en       = 1'b1;
        mem_we       = 1'b1;
        mem_addr     = ptr_addr;
        mem_wdata    = pmm_pkg::BYTE_W'(tbl_r);
        have_tbl_nxt = 1'b1;
        i_nxt        = '0;
        if (cnt_r == '0) begin
          state_nxt = S_ZFL;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ALC_RD;
        end
      end

      S_EWR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = ent_addr;
        mem_wdata = pmm_pkg::BYTE_W'(j_r);
        i_nxt     = i_r + 1'b1;
        if ((pmm_pkg::CNT_W'(i_r) + 1'b1) == cnt_r) begin
          state_nxt = S_ZFL;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ALC_RD;
        end
      end

      // clear the unmapped tail of the new table
      S_ZFL: begin
        if (i_r == CW'(NUM_PAGES)) begin
          state_nxt = S_DONE;
        end else begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = ent_addr;
          mem_wdata = '0;
          i_nxt     = i_r + 1'b1;
        end
      end

      S_KRD: begin
        mem_en    = 1'b1;
        mem_addr  = ent_addr;
        state_nxt = S_KCHK;
      end

      S_KCHK: begin
        if (!rd_zero && rd_page) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = AW'(mem_rdata[PW-1:0]);
          mem_wdata = '0;
        end
        if (i_r == CW'(NUM_PAGES - 1)) begin
          state_nxt = S_KTBL;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_KRD;
        end
      end

      S_KTBL: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = AW'(tbl_r);
        mem_wdata = '0;
        state_nxt = S_KPTR;
      end

      S_KPTR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = ptr_addr;
        mem_wdata = '0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    free_r     <= free_nxt;
    tbl_r      <= tbl_nxt;
    have_tbl_r <= have_tbl_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

[tb/page_table_checker.sv]
`timescale 1ns / 100ps
module page_table_checker #(
  parameter int NUM_PAGES  = 64,
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic [39:0] in_tdata,   // [5:0] process_number, [12:6] npages,
                                  // [26:13] vaddr, [34:27] write_data
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic [23:0] out_tdata,  // [13:0] paddr, [21:14] read_data
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          error_results
);

  localparam int MEM_BYTES = NUM_PAGES * PAGE_BYTES;

  logic [7:0]       mem_image [MEM_BYTES];
  pmm_pkg::result_t predicted_results [$];

  // table page of a process, 0 when it does not exist
  function automatic int table_page(input logic [pmm_pkg::PROC_W-1:0] proc);
    int t;
    t = mem_image[pmm_pkg::PTR_BASE + proc];
    return (t < NUM_PAGES) ? t : 0;
  endfunction

  function automatic int lowest_free_page();
    for (int i = 0; i < NUM_PAGES; i++)
      if (mem_image[i] == 8'd0) return i;
    return 0;
  endfunction

  function automatic logic [1:0] create_process(input pmm_pkg::item_t w);
    int want;
    int free_pages;
    int tbl;
    int pg;
    if (mem_image[pmm_pkg::PTR_BASE + w.process_number] != 8'd0) return pmm_pkg::ST_OK;
    want = (w.npages > NUM_PAGES) ? NUM_PAGES : w.npages;
    free_pages = 0;
    for (int i = 0; i < NUM_PAGES; i++)
      if (mem_image[i] == 8'd0) free_pages++;
    if (free_pages < want + 1) return pmm_pkg::ST_NO_FREE;
    tbl = lowest_free_page();
    mem_image[tbl] = 8'd1;
    mem_image[pmm_pkg::PTR_BASE + w.process_number] = tbl[7:0];
    for (int i = 0; i < NUM_PAGES; i++) begin
      pg = 0;
      if (i < want) begin
        pg = lowest_free_page();
        mem_image[pg] = 8'd1;
      end
      mem_image[tbl * PAGE_BYTES + i] = pg[7:0];
    end
    return pmm_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] remove_proc(input logic [pmm_pkg::PROC_W-1:0] proc);
    int tbl;
    int entry;
    tbl = table_page(proc);
    if (tbl == 0) return pmm_pkg::ST_NO_PROC;
    for (int i = 0; i < NUM_PAGES; i++) begin
      entry = mem_image[tbl * PAGE_BYTES + i];
      if (entry != 0 && entry < NUM_PAGES) mem_image[entry] = 8'd0;
    end
    mem_image[tbl] = 8'd0;
    mem_image[pmm_pkg::PTR_BASE + proc] = 8'd0;
    return pmm_pkg::ST_OK;
  endfunction

  // apply one word to the memory image and return the result it yields
  function automatic pmm_pkg::result_t predict_result(input pmm_pkg::item_t w);
    pmm_pkg::result_t r;
    int               tbl;
    int               vpage;
    int               entry;
    int               phys;
    r = '0;
    case (w.opcode)
      pmm_pkg::OP_NEW:  r.status = create_process(w);
      pmm_pkg::OP_KILL: r.status = remove_proc(w.process_number);
      default: begin
        tbl = table_page(w.process_number);
        vpage = w.vaddr / PAGE_BYTES;
        if (tbl == 0) begin
          r.status = pmm_pkg::ST_NO_PROC;
        end else if (vpage >= NUM_PAGES) begin
          r.status = pmm_pkg::ST_UNMAPPED;
        end else begin
          entry = mem_image[tbl * PAGE_BYTES + vpage];
          if (entry == 0 || entry >= NUM_PAGES) begin
            r.status = pmm_pkg::ST_UNMAPPED;
          end else begin
            phys = entry * PAGE_BYTES + w.vaddr % PAGE_BYTES;
            r.paddr = phys[pmm_pkg::PA_W-1:0];
            if (w.opcode == pmm_pkg::OP_LOAD) r.read_data = mem_image[phys];
            else mem_image[phys] = w.write_data;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pmm_pkg::result_t got;
    pmm_pkg::result_t want;
    pmm_pkg::item_t   w;
    if (!rst_n) begin
      foreach (mem_image[i]) mem_image[i] = 8'd0;
      mem_image[0] = 8'd1;
      predicted_results.delete();
      fail_count = 0;
      results_checked = 0;
      error_results = 0;
    end else begin
      // check the outgoing word first: it can never belong to a word taken at this edge
      if (out_tvalid && out_tready) begin
        got.paddr = out_tdata[13:0];
        got.read_data = out_tdata[21:14];
        got.status = out_tuser;
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none outstanding: pa=%h rd=%h status=%0d",
                     $time, got.paddr, got.read_data, got.status);
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          if (want.status != pmm_pkg::ST_OK) error_results++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp pa=%h rd=%h st=%0d, got pa=%h rd=%h st=%0d",
                       $time, want.paddr, want.read_data, want.status,
                       got.paddr, got.read_data, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w.opcode = in_tuser;
        w.process_number = in_tdata[5:0];
        w.npages = in_tdata[12:6];
        w.vaddr = in_tdata[26:13];
        w.write_data = in_tdata[34:27];
        predicted_results.push_back(predict_result(w));
      end
    end
    pending <= predicted_results.size();
  end

endmodule

[tb/paged_memory_manager_test.sv]
`timescale 1ns / 100ps
module paged_memory_manager_test;

  localparam int NUM_PAGES    = 64;
  localparam int PAGE_BYTES   = 256;
  localparam int DIRECTED     = 24;
  localparam int RANDOM_WORDS = 1080;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 5_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [23:0] out_tdata;

  logic rx_hold = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   words_sent = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   results_checked;
  int   error_results;

  initial begin
    forever #6 clk = ~clk;
  end

  paged_memory_manager #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  page_table_checker #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tuser      (out_tuser),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .error_results  (error_results)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Run stopped at the cycle limit with %0d results outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // long output stall early in the last phase so the block backs up into its input
  initial begin
    wait (words_sent >= DIRECTED + 2 * (RANDOM_WORDS / 3) + 20);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic pmm_pkg::item_t pack_word(input logic [1:0] op, input int proc,
                                               input int cnt, input int va,
                                               input int wd);
    pmm_pkg::item_t w;
    w.opcode = op;
    w.process_number = proc[pmm_pkg::PROC_W-1:0];
    w.npages = cnt[pmm_pkg::CNT_W-1:0];
    w.vaddr = va[pmm_pkg::VA_W-1:0];
    w.write_data = wd[pmm_pkg::BYTE_W-1:0];
    return w;
  endfunction

  task automatic send_word(input pmm_pkg::item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.opcode;
    in_tdata <= {5'd0, w.write_data, w.vaddr, w.npages, w.process_number};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // mostly traffic on a small set of live processes, some words over the full field ranges
  task automatic send_random_word();
    logic [1:0] op;
    int         roll;
    int         proc;
    int         cnt;
    int         va;
    roll = $urandom_range(99);
    if (roll < 12) op = pmm_pkg::OP_NEW;
    else if (roll < 20) op = pmm_pkg::OP_KILL;
    else if (roll < 60) op = pmm_pkg::OP_LOAD;
    else op = pmm_pkg::OP_STORE;
    proc = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(63);
    roll = $urandom_range(99);
    if (roll < 70) cnt = $urandom_range(6);
    else if (roll < 90) cnt = $urandom_range(20, 7);
    else cnt = $urandom_range(127);
    if ($urandom_range(99) < 80)
      va = $urandom_range(7) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
    else
      va = $urandom_range(16383);
    send_word(pack_word(op, proc, cnt, va, $urandom_range(255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 6;
    rx_idle_pct = 51;

    // nothing exists yet
    send_word(pack_word(pmm_pkg::OP_LOAD, 0, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_KILL, 63, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_STORE, 5, 0, 100, 8'h5a));
    // process with a table but no data pages, then one with two data pages
    send_word(pack_word(pmm_pkg::OP_NEW, 0, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_LOAD, 0, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_NEW, 63, 2, 0, 0));
    send_word(pack_word(pmm_pkg::OP_STORE, 63, 0, 511, 8'hff));
    send_word(pack_word(pmm_pkg::OP_LOAD, 63, 0, 511, 0));
    send_word(pack_word(pmm_pkg::OP_LOAD, 63, 0, 16383, 0));
    // existing process is left alone
    send_word(pack_word(pmm_pkg::OP_NEW, 63, 5, 0, 0));
    // oversized requests saturate and then run out of pages
    send_word(pack_word(pmm_pkg::OP_NEW, 1, 127, 0, 0));
    send_word(pack_word(pmm_pkg::OP_NEW, 1, 64, 0, 0));
    // take every remaining page
    send_word(pack_word(pmm_pkg::OP_NEW, 1, 58, 0, 0));
    send_word(pack_word(pmm_pkg::OP_NEW, 2, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_STORE, 1, 0, 57 * PAGE_BYTES + 128, 8'ha5));
    send_word(pack_word(pmm_pkg::OP_LOAD, 1, 0, 57 * PAGE_BYTES + 128, 0));
    send_word(pack_word(pmm_pkg::OP_KILL, 1, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_LOAD, 1, 0, 57 * PAGE_BYTES + 128, 0));
    send_word(pack_word(pmm_pkg::OP_KILL, 63, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_KILL, 0, 0, 0, 0));
    send_word(pack_word(pmm_pkg::OP_NEW, 2, 64, 0, 0));
    send_word(pack_word(pmm_pkg::OP_NEW, 2, 62, 0, 0));
    // process 2 has no data pages, so this load is unmapped
    send_word(pack_word(pmm_pkg::OP_LOAD, 2, 0, 3 * PAGE_BYTES + 255, 0));
    send_word(pack_word(pmm_pkg::OP_KILL, 2, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_WORDS / 3) send_random_word();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d words: process create, kill, page exhaustion and translation cases,",
             words_sent);
    $display("then random traffic under three idle profiles and a %0d-cycle output stall;",
             HOLD_CYCLES);
    $display("%0d results checked, %0d with error status", results_checked, error_results);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pmm_pkg.sv
sv/pmm_mem.sv
sv/pmm_seq.sv
sv/paged_memory_manager.sv
tb/page_table_checker.sv
tb/paged_memory_manager_test.sv
